// File: design/kbrkt_pkg.sv
// kbrkt_pkg: shared types and constants for the keyboard report key table.
// No dependencies; imported by every module of the block.
`default_nettype none

package kbrkt_pkg;

    localparam int KEY_SLOTS_DEF = 6;
    localparam int SHOWN_SLOTS   = 6;
    localparam int CODE_W        = 8;
    localparam int MOD_BITS      = 8;
    localparam int MOD_SEL_W     = 3;

    typedef enum logic [1:0] {
        OP_QUERY_KEY = 2'd0,
        OP_WRITE_KEY = 2'd1,
        OP_QUERY_MOD = 2'd2,
        OP_WRITE_MOD = 2'd3
    } t_op;

    typedef enum logic {
        ST_OK      = 1'b0,
        ST_BAD_MOD = 1'b1
    } t_status;

    typedef struct packed {
        t_op              operation;
        logic [7:0]       usage_code;
        logic [7:0]       modifier_index;
        logic             press;
        logic             buffer_select;
    } t_in_word;

    typedef struct packed {
        t_status          status;
        logic             found;
        logic [7:0]       modifier_byte;
        logic [7:0]       slot_zero;
        logic [7:0]       slot_one;
        logic [7:0]       slot_two;
        logic [7:0]       slot_three;
        logic [7:0]       slot_four;
        logic [7:0]       slot_five;
    } t_out_word;

    // broadcast to every slot cell
    typedef struct packed {
        logic              en;
        logic              wr_key;
        logic              press;
        logic              sel;
        logic [CODE_W-1:0] code;
    } t_cell_cmd;

    // left-to-right link between neighboring cells
    typedef struct packed {
        logic done;
        logic shift;
        logic found;
    } t_link;

    typedef struct packed {
        t_status             status;
        logic                found;
        logic [MOD_BITS-1:0] next_byte;
    } t_mod_res;

endpackage

`default_nettype wire

// File: design/kbrkt_cell.sv
// kbrkt_cell: one key slot position, holding that slot for both reports.
// Depends on kbrkt_pkg; chained by keyboard_report_key_table.
`default_nettype none

module kbrkt_cell
    import kbrkt_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_cell_cmd         i_cmd,
    input  wire t_link             i_link,
    input  wire logic [CODE_W-1:0] i_right_slot,
    output t_link                  o_link,
    output logic [CODE_W-1:0]      o_cur_slot,
    output logic [CODE_W-1:0]      o_next_slot
);

    logic [CODE_W-1:0] r_slot [2];
    logic [CODE_W-1:0] cur;
    logic [CODE_W-1:0] n_slot;
    logic              hit;
    logic              empty;
    logic              fill;
    logic              take;

    always_comb begin
        cur   = r_slot[i_cmd.sel];
        hit   = (cur == i_cmd.code);
        empty = (cur == '0);
        fill  = !i_link.done && empty;
        take  = i_link.shift || hit;
        n_slot = cur;
        if (i_cmd.wr_key) begin
            if (i_cmd.press) begin
                if (fill) begin
                    n_slot = i_cmd.code;
                end
            end else if (take) begin
                n_slot = i_right_slot;
            end
        end
        o_link.done  = i_link.done || empty || hit;
        o_link.shift = take;
        o_link.found = i_link.found || hit;
    end

    assign o_cur_slot  = cur;
    assign o_next_slot = n_slot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot[0] <= '0;
            r_slot[1] <= '0;
        end else if (i_cmd.en) begin
            r_slot[i_cmd.sel] <= n_slot;
        end
    end

endmodule

`default_nettype wire

// File: design/kbrkt_mod.sv
// kbrkt_mod: modifier bytes of both reports and the bit query/write logic.
// Depends on kbrkt_pkg; instantiated by keyboard_report_key_table.
`default_nettype none

module kbrkt_mod
    import kbrkt_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_en,
    input  wire t_in_word i_word,
    output t_mod_res  o_res
);

    logic [MOD_BITS-1:0] r_mod [2];
    logic [MOD_BITS-1:0] cur;
    logic [MOD_BITS-1:0] bit_mask;
    logic                bad;

    always_comb begin
        cur      = r_mod[i_word.buffer_select];
        bad      = |i_word.modifier_index[7:MOD_SEL_W];
        bit_mask = MOD_BITS'(1) << i_word.modifier_index[MOD_SEL_W-1:0];
        o_res.status    = ST_OK;
        o_res.found     = 1'b0;
        o_res.next_byte = cur;
        unique case (i_word.operation)
            OP_QUERY_MOD: begin
                if (bad) begin
                    o_res.status = ST_BAD_MOD;
                end else begin
                    o_res.found = |(cur & bit_mask);
                end
            end
            OP_WRITE_MOD: begin
                if (bad) begin
                    o_res.status = ST_BAD_MOD;
                end else if (i_word.press) begin
                    o_res.next_byte = cur | bit_mask;
                end else begin
                    o_res.next_byte = cur & ~bit_mask;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod[0] <= '0;
            r_mod[1] <= '0;
        end else if (i_en) begin
            r_mod[i_word.buffer_select] <= o_res.next_byte;
        end
    end

endmodule

`default_nettype wire

// File: design/keyboard_report_key_table.sv
// keyboard_report_key_table: top level, a row of slot cells plus the modifier unit.
// Depends on kbrkt_pkg, kbrkt_cell and kbrkt_mod.
//
//  channel | valid       | stall        | word
//  --------+-------------+--------------+-------------
//  in      | i_in_valid  | o_in_stall   | i_in_word
//  out     | o_out_valid | i_out_stall  | o_out_word
//
// One word per cycle unless the input stalls: the cell row resolves a key op
// combinationally, and its result is registered on the accepting edge.
// Reset clears both reports and the output valid.
// The input stalls only while a result sits in the output register and the
// output side stalls.
`default_nettype none

module keyboard_report_key_table
    import kbrkt_pkg::*;
#(
    parameter int KEY_SLOTS = KEY_SLOTS_DEF
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_stall,
    input  wire t_in_word i_in_word,
    output logic          o_out_valid,
    input  wire logic     i_out_stall,
    output t_out_word     o_out_word
);

    logic              accept;
    t_cell_cmd         cmd;
    t_link             link      [KEY_SLOTS+1];
    logic [CODE_W-1:0] cur_slot  [KEY_SLOTS+1];
    logic [CODE_W-1:0] next_slot [KEY_SLOTS];
    logic [CODE_W-1:0] shown     [SHOWN_SLOTS];
    t_mod_res          mod_res;
    t_out_word         n_out;
    logic              r_out_valid;
    t_out_word         r_out;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        cmd.en     = accept && (i_in_word.operation == OP_WRITE_KEY);
        cmd.wr_key = (i_in_word.operation == OP_WRITE_KEY);
        cmd.press  = i_in_word.press;
        cmd.sel    = i_in_word.buffer_select;
        cmd.code   = i_in_word.usage_code;
    end

    assign link[0]             = '0;
    assign cur_slot[KEY_SLOTS] = '0;

    for (genvar i = 0; i < KEY_SLOTS; i++) begin : g_cell
        kbrkt_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_cmd        (cmd),
            .i_link       (link[i]),
            .i_right_slot (cur_slot[i+1]),
            .o_link       (link[i+1]),
            .o_cur_slot   (cur_slot[i]),
            .o_next_slot  (next_slot[i])
        );
    end

    kbrkt_mod u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (accept && (i_in_word.operation == OP_WRITE_MOD)),
        .i_word  (i_in_word),
        .o_res   (mod_res)
    );

    for (genvar j = 0; j < SHOWN_SLOTS; j++) begin : g_shown
        if (j < KEY_SLOTS) begin : g_real
            assign shown[j] = next_slot[j];
        end else begin : g_zero
            assign shown[j] = '0;
        end
    end

    always_comb begin
        n_out.status        = mod_res.status;
        n_out.found         = mod_res.found;
        if (i_in_word.operation == OP_QUERY_KEY) begin
            n_out.found = link[KEY_SLOTS].found;
        end
        n_out.modifier_byte = mod_res.next_byte;
        n_out.slot_zero     = shown[0];
        n_out.slot_one      = shown[1];
        n_out.slot_two      = shown[2];
        n_out.slot_three    = shown[3];
        n_out.slot_four     = shown[4];
        n_out.slot_five     = shown[5];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

endmodule

`default_nettype wire

// File: design/kbrkt_checker.sv
// kbrkt_checker: port-level assertions for keyboard_report_key_table, bound below.
// Depends on kbrkt_pkg.
`default_nettype none

module kbrkt_checker
    import kbrkt_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      i_in_valid,
    input wire logic      o_in_stall,
    input wire t_in_word  i_in_word,
    input wire logic      o_out_valid,
    input wire logic      i_out_stall,
    input wire t_out_word o_out_word
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_word)))
        else $error("stalled output word changed");

    a_in_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_out_valid)
        else $error("accepted word produced no result");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without a held result");

    a_bad_mod: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && (i_in_word.modifier_index[7:3] != 5'd0)
         && (i_in_word.operation == OP_QUERY_MOD || i_in_word.operation == OP_WRITE_MOD))
        |=> (o_out_word.status == ST_BAD_MOD && !o_out_word.found))
        else $error("bad modifier index not flagged");

endmodule

bind keyboard_report_key_table kbrkt_checker u_kbrkt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_word   (i_in_word),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_word  (o_out_word)
);

`default_nettype wire

// File: dv/tb_top.sv
// tb_top: self-checking testbench for keyboard_report_key_table.
// Depends on kbrkt_pkg and the keyboard_report_key_table RTL; models both
// reports locally and checks every result word against that model.
`timescale 1ns / 1ps

module tb_top;
    import kbrkt_pkg::*;

    localparam int NKEYS        = KEY_SLOTS_DEF;
    localparam int HOLD_CYCLES  = 300;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 10;

    typedef enum int {
        STALL_NONE,
        STALL_RANDOM,
        STALL_PATTERN
    } t_stall_mode;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_word  i_in_word   = '0;
    logic      i_out_stall = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_word o_out_word;

    logic [7:0] model_keys [2][NKEYS];
    logic [7:0] model_mods [2];
    t_out_word  expected_reports[$];

    int          err_count  = 0;
    int          n_sent     = 0;
    int          n_checked  = 0;
    int          n_ops [4]  = '{0, 0, 0, 0};
    int          n_bad_mod  = 0;
    int          burst_left = 0;
    int          gap_max    = 0;
    int          stall_pct  = 0;
    t_stall_mode stall_mode = STALL_NONE;
    int          hold_req   = 0;
    int          hold_ack   = 0;
    int          hold_left  = 0;
    int          pat_cnt    = 0;
    int          cycles     = 0;

    keyboard_report_key_table #(
        .KEY_SLOTS(NKEYS)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_word  (i_in_word),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_word (o_out_word)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("TEST FAILED");
            $finish;
        end
    end

    // output side: random or periodic stalls, plus long holds on request
    always @(posedge i_clk) begin
        pat_cnt <= pat_cnt + 1;
        if (hold_ack != hold_req) begin
            hold_ack    <= hold_req;
            hold_left   <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            case (stall_mode)
                STALL_RANDOM:  i_out_stall <= ($urandom_range(0, 99) < stall_pct);
                STALL_PATTERN: i_out_stall <= ((pat_cnt % 11) < 4) || ((pat_cnt % 37) == 20);
                default:       i_out_stall <= 1'b0;
            endcase
        end
    end

    function automatic t_out_word apply_word(t_in_word w);
        t_out_word  r;
        logic [7:0] shown [SHOWN_SLOTS];
        int         s;
        int         hit;
        s        = int'(w.buffer_select);
        r        = '0;
        r.status = ST_OK;
        hit      = -1;
        case (w.operation)
            OP_QUERY_KEY: begin
                for (int i = 0; i < NKEYS; i++) begin
                    if (model_keys[s][i] == w.usage_code) r.found = 1'b1;
                end
            end
            OP_WRITE_KEY: begin
                if (w.press) begin
                    // first empty slot, unless the key already sits earlier
                    for (int i = 0; i < NKEYS; i++) begin
                        if (hit < 0 && (model_keys[s][i] == 8'd0 ||
                                        model_keys[s][i] == w.usage_code)) begin
                            hit = i;
                        end
                    end
                    if (hit >= 0 && model_keys[s][hit] == 8'd0) begin
                        model_keys[s][hit] = w.usage_code;
                    end
                end else begin
                    for (int i = 0; i < NKEYS; i++) begin
                        if (hit < 0 && model_keys[s][i] == w.usage_code) hit = i;
                    end
                    if (hit >= 0) begin
                        for (int j = hit; j < NKEYS - 1; j++) begin
                            model_keys[s][j] = model_keys[s][j + 1];
                        end
                        model_keys[s][NKEYS - 1] = 8'd0;
                    end
                end
            end
            OP_QUERY_MOD: begin
                if (w.modifier_index >= MOD_BITS) begin
                    r.status = ST_BAD_MOD;
                end else begin
                    r.found = model_mods[s][w.modifier_index[MOD_SEL_W-1:0]];
                end
            end
            default: begin
                if (w.modifier_index >= MOD_BITS) begin
                    r.status = ST_BAD_MOD;
                end else begin
                    model_mods[s][w.modifier_index[MOD_SEL_W-1:0]] = w.press;
                end
            end
        endcase
        for (int j = 0; j < SHOWN_SLOTS; j++) begin
            shown[j] = (j < NKEYS) ? model_keys[s][j] : 8'd0;
        end
        r.modifier_byte = model_mods[s];
        r.slot_zero     = shown[0];
        r.slot_one      = shown[1];
        r.slot_two      = shown[2];
        r.slot_three    = shown[3];
        r.slot_four     = shown[4];
        r.slot_five     = shown[5];
        return r;
    endfunction

    task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            err_count++;
        end
    endtask

    task automatic compare_report(t_out_word want, t_out_word got);
        check_field("status", 8'(want.status), 8'(got.status));
        check_field("found", 8'(want.found), 8'(got.found));
        check_field("modifier_byte", want.modifier_byte, got.modifier_byte);
        check_field("slot_zero", want.slot_zero, got.slot_zero);
        check_field("slot_one", want.slot_one, got.slot_one);
        check_field("slot_two", want.slot_two, got.slot_two);
        check_field("slot_three", want.slot_three, got.slot_three);
        check_field("slot_four", want.slot_four, got.slot_four);
        check_field("slot_five", want.slot_five, got.slot_five);
    endtask

    always @(posedge i_clk) begin : monitor
        t_out_word want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_reports.size() == 0) begin
                    $error("result word with nothing expected: %h", o_out_word);
                    err_count++;
                end else begin
                    want = expected_reports.pop_front();
                    compare_report(want, o_out_word);
                    n_checked++;
                end
            end
            if (i_in_valid && !o_in_stall) begin
                want = apply_word(i_in_word);
                expected_reports.push_back(want);
                n_ops[int'(i_in_word.operation)]++;
                if (want.status == ST_BAD_MOD) n_bad_mod++;
            end
        end
    end

    function automatic t_in_word make_word(t_op op, logic [7:0] code, logic [7:0] idx,
                                           logic press, logic sel);
        t_in_word w;
        w.operation      = op;
        w.usage_code     = code;
        w.modifier_index = idx;
        w.press          = press;
        w.buffer_select  = sel;
        return w;
    endfunction

    function automatic logic [7:0] rand_code();
        case ($urandom_range(0, 9))
            0:             return 8'd0;
            1, 2, 3, 4, 5: return 8'($urandom_range(1, 12));
            default:       return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [7:0] rand_idx();
        if ($urandom_range(0, 4) == 0) return 8'($urandom_range(0, 255));
        return 8'($urandom_range(0, MOD_BITS - 1));
    endfunction

    function automatic t_in_word noise_word();
        logic [31:0]                 r32;
        logic [$bits(t_in_word)-1:0] raw;
        r32 = $urandom;
        raw = r32[$bits(t_in_word)-1:0];
        return raw;
    endfunction

    task automatic send_word(t_in_word w);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap        = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do @(posedge i_clk); while (o_in_stall);
        n_sent++;
    endtask

    task automatic wait_all_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (expected_reports.size() != 0);
    endtask

    task automatic test_directed();
        gap_max    = 0;
        stall_mode = STALL_RANDOM;
        stall_pct  = 30;
        send_word(make_word(OP_QUERY_KEY, 8'd0, 8'd0, 1'b0, 1'b0));
        send_word(make_word(OP_QUERY_KEY, 8'hFF, 8'd0, 1'b0, 1'b0));
        send_word(make_word(OP_WRITE_KEY, 8'd0, 8'd0, 1'b1, 1'b0));
        send_word(make_word(OP_WRITE_KEY, 8'd4, 8'd0, 1'b1, 1'b0));
        send_word(make_word(OP_WRITE_KEY, 8'd5, 8'd0, 1'b1, 1'b0));
        send_word(make_word(OP_WRITE_KEY, 8'd6, 8'd0, 1'b1, 1'b0));
        send_word(make_word(OP_WRITE_KEY, 8'd7, 8'd0, 1'b1, 1'b0));
        send_word(make_word(OP_WRITE_KEY, 8'd8, 8'd0, 1'b1, 1'b0));
        send_word(make_word(OP_WRITE_KEY, 8'hFF, 8'd0, 1'b1, 1'b0));
        send_word(make_word(OP_WRITE_KEY, 8'd9, 8'd0, 1'b1, 1'b0));
        send_word(make_word(OP_WRITE_KEY, 8'd5, 8'd0, 1'b1, 1'b0));
        send_word(make_word(OP_QUERY_KEY, 8'd0, 8'd0, 1'b0, 1'b0));
        send_word(make_word(OP_QUERY_KEY, 8'hFF, 8'd0, 1'b0, 1'b0));
        send_word(make_word(OP_WRITE_KEY, 8'd6, 8'd0, 1'b0, 1'b0));
        send_word(make_word(OP_WRITE_KEY, 8'd0, 8'd0, 1'b0, 1'b0));
        send_word(make_word(OP_WRITE_KEY, 8'd200, 8'd0, 1'b0, 1'b0));
        send_word(make_word(OP_QUERY_KEY, 8'd4, 8'd0, 1'b0, 1'b1));
        send_word(make_word(OP_WRITE_MOD, 8'd0, 8'd0, 1'b1, 1'b1));
        send_word(make_word(OP_WRITE_MOD, 8'd0, 8'd7, 1'b1, 1'b1));
        send_word(make_word(OP_QUERY_MOD, 8'd0, 8'd7, 1'b0, 1'b1));
        send_word(make_word(OP_QUERY_MOD, 8'd0, 8'd8, 1'b0, 1'b1));
        send_word(make_word(OP_WRITE_MOD, 8'd0, 8'hFF, 1'b1, 1'b0));
        send_word(make_word(OP_WRITE_MOD, 8'd0, 8'd0, 1'b0, 1'b1));
        send_word(make_word(OP_QUERY_MOD, 8'hFF, 8'd0, 1'b1, 1'b0));
        send_word(make_word(OP_WRITE_KEY, 8'd4, 8'd128, 1'b0, 1'b0));
        wait_all_results();
    endtask

    task automatic test_random_mix(int n);
        gap_max    = 3;
        stall_mode = STALL_RANDOM;
        stall_pct  = 50;
        for (int i = 0; i < n; i++) begin
            if (i == n / 2) begin
                gap_max    = 0;
                stall_mode = STALL_NONE;
            end
            send_word(make_word(t_op'($urandom_range(0, 3)), rand_code(), rand_idx(),
                                1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
        end
        wait_all_results();
    endtask

    task automatic side_op(logic sel, logic [7:0] held[$]);
        logic [7:0] code;
        case ($urandom_range(0, 9))
            0: send_word(noise_word());
            1, 2, 3: begin
                code = (held.size() != 0 && $urandom_range(0, 1))
                     ? held[$urandom_range(0, held.size() - 1)] : rand_code();
                send_word(make_word(OP_QUERY_KEY, code, rand_idx(), 1'b0, sel));
            end
            4, 5: send_word(make_word(OP_WRITE_MOD, rand_code(), rand_idx(),
                                      1'($urandom_range(0, 1)), sel));
            6: send_word(make_word(OP_QUERY_MOD, rand_code(), rand_idx(), 1'b0, sel));
            default: ;
        endcase
    endtask

    task automatic test_typing_sequences(int n);
        logic [7:0] held[$];
        logic [7:0] code;
        logic       sel;
        int         k;
        int         pick;
        int         start;
        start = n_sent;
        while (n_sent - start < n) begin
            gap_max    = $urandom_range(0, 1) ? 0 : $urandom_range(1, 6);
            stall_mode = t_stall_mode'($urandom_range(0, 2));
            stall_pct  = $urandom_range(10, 70);
            sel        = 1'($urandom_range(0, 1));
            k          = $urandom_range(1, 8);
            held.delete();
            for (int i = 0; i < k; i++) begin
                code = $urandom_range(0, 1) ? 8'($urandom_range(1, 12))
                                            : 8'($urandom_range(1, 255));
                held.push_back(code);
                send_word(make_word(OP_WRITE_KEY, code, rand_idx(), 1'b1, sel));
                side_op(sel, held);
            end
            // usually release everything, in random order; sometimes leave some down
            while (held.size() != 0 && $urandom_range(0, 15) != 0) begin
                pick = $urandom_range(0, held.size() - 1);
                code = held[pick];
                held.delete(pick);
                send_word(make_word(OP_WRITE_KEY, code, rand_idx(), 1'b0, sel));
                side_op(sel, held);
            end
        end
        wait_all_results();
    endtask

    task automatic test_output_hold(int n);
        gap_max    = 0;
        stall_mode = STALL_NONE;
        hold_req++;
        for (int i = 0; i < n; i++) begin
            send_word(make_word(t_op'($urandom_range(0, 3)), rand_code(), rand_idx(),
                                1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
        end
        wait_all_results();
    endtask

    task automatic test_pause_and_drain(int rounds);
        gap_max    = 2;
        stall_mode = STALL_PATTERN;
        for (int r = 0; r < rounds; r++) begin
            for (int i = 0; i < 20; i++) begin
                send_word(make_word(t_op'($urandom_range(0, 3)), rand_code(), rand_idx(),
                                    1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
            end
            wait_all_results();
        end
    endtask

    initial begin
        for (int s = 0; s < 2; s++) begin
            model_mods[s] = 8'd0;
            for (int i = 0; i < NKEYS; i++) model_keys[s][i] = 8'd0;
        end
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_output_hold(60);
        test_random_mix(600);
        test_pause_and_drain(3);
        test_typing_sequences(1100);

        wait_all_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d words sent (key query %0d, key write %0d, mod query %0d, mod write %0d)",
                 n_sent, n_ops[OP_QUERY_KEY], n_ops[OP_WRITE_KEY], n_ops[OP_QUERY_MOD],
                 n_ops[OP_WRITE_MOD]);
        $display("%0d results checked, %0d bad modifier indexes, long output hold and drains",
                 n_checked, n_bad_mod);
        if (err_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// File: keyboard_report_key_table.f
design/kbrkt_pkg.sv
design/kbrkt_cell.sv
design/kbrkt_mod.sv
design/keyboard_report_key_table.sv
design/kbrkt_checker.sv
dv/tb_top.sv
